/* rtl/grdfs_pkg.sv */
// Shared types, field widths, operation codes and defaults for the reachability unit.
package grdfs_pkg;

    localparam int MAX_NODES_DEF = 64;

    localparam int OP_W   = 2;
    localparam int NODE_W = 7;
    localparam int CNT_W  = 7;

    typedef logic [OP_W-1:0]   op_t;
    typedef logic [NODE_W-1:0] node_id_t;
    typedef logic [CNT_W-1:0]  node_cnt_t;

    localparam op_t OP_ADD_EDGE  = 2'd0;
    localparam op_t OP_QUERY     = 2'd1;
    localparam op_t OP_CLEAR_ALL = 2'd2;
    localparam op_t OP_UNUSED    = 2'd3;

    localparam node_cnt_t NODE_CNT_RST = 7'd64;

endpackage

/* rtl/grdfs_if.sv */
// Valid/ready channel interfaces for the command and result beats.
interface grdfs_in_if;
    import grdfs_pkg::*;

    logic     valid;
    logic     ready;
    op_t      op;
    node_id_t from_node;
    node_id_t to_node;

    modport source (output valid, output op, output from_node, output to_node, input ready);
    modport sink   (input valid, input op, input from_node, input to_node, output ready);
endinterface

interface grdfs_out_if;
    logic valid;
    logic ready;
    logic reachable;
    logic bad_node;

    modport source (output valid, output reachable, output bad_node, input ready);
    modport sink   (input valid, input reachable, input bad_node, output ready);
endinterface

/* rtl/graph_reachability_dfs_unit.sv */
// Directed-graph store with depth-first reachability queries over an adjacency memory.
//
// Usage: command beats arrive on in_ch (op, from_node, to_node); every command
// produces exactly one result beat on out_ch (reachable, bad_node). Op 0 adds an
// edge, op 2 drops every edge, op 1 walks the graph from from_node and reports
// whether to_node is reached through a path of at least one edge. Node ids run
// from 1 to the node count in use, which is cfg_wr_data (written with cfg_wr_en)
// capped at MAX_NODES. The node count register may only be written while idle.
//
// Sequencing: clear, rejected and unused commands go straight to the result
// state; adding an edge passes a row read and a row write-back first. A query
// takes each popped node through pop, row read, row scan and end of pushes, and
// writes each pushed node to the stack on its own, as each memory has one read
// port. One command at a time.
//
// Stalls: a finished result sits in an output register, so the next command is
// accepted while the receiver holds off ready; that command then waits in its
// last state until the output register frees up.
// Reset: the edge store reads as empty through per-row valid flip-flops, so the
// unit is ready once reset is released. The node count resets to 64.
module graph_reachability_dfs_unit #(
    parameter int MAX_NODES = grdfs_pkg::MAX_NODES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    grdfs_in_if.sink            in_ch,
    grdfs_out_if.source         out_ch,
    input  logic                cfg_wr_en,
    input  grdfs_pkg::node_cnt_t cfg_wr_data
);
    import grdfs_pkg::*;

    // Widths derived from the node limit.
    localparam int IDX_W       = $clog2(MAX_NODES);
    localparam int LIM_CW      = $clog2(MAX_NODES + 1);
    localparam int LW          = (LIM_CW > NODE_W) ? LIM_CW : NODE_W;
    localparam int STACK_DEPTH = MAX_NODES + 1;
    localparam int SI_W        = $clog2(STACK_DEPTH);
    localparam int SF_W        = $clog2(STACK_DEPTH + 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ADD_RD = 4'd1;
    localparam logic [3:0] S_ADD_WR = 4'd2;
    localparam logic [3:0] S_Q_RD   = 4'd3;
    localparam logic [3:0] S_Q_EXP  = 4'd4;
    localparam logic [3:0] S_Q_PUSH = 4'd5;
    localparam logic [3:0] S_Q_POP  = 4'd6;
    localparam logic [3:0] S_Q_POPW = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    typedef logic [MAX_NODES-1:0] row_t;
    typedef logic [IDX_W-1:0]     idx_t;

    // Lowest set bit of a row; the caller only uses it when the row is nonzero.
    function automatic idx_t first_set(input row_t v);
        idx_t idx;
        idx = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = idx_t'(i);
            end
        end
        return idx;
    endfunction

    // Memories: adjacency rows and the walk stack.
    row_t adj_mem [MAX_NODES];
    idx_t stk_mem [STACK_DEPTH];

    logic [3:0]      state_reg, state_next;
    node_cnt_t       node_count_reg;
    row_t            row_vld_reg, row_vld_next;
    row_t            disc_reg, disc_next;
    row_t            pend_reg, pend_next;
    logic [SF_W-1:0] fill_reg, fill_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_reach_reg, out_reach_next;
    logic            out_bad_reg, out_bad_next;
    logic            res_reach_reg, res_reach_next;
    logic            res_bad_reg, res_bad_next;
    idx_t            from_idx_reg, from_idx_next;
    idx_t            to_idx_reg, to_idx_next;

    // Memory port signals.
    logic            adj_rd_en;
    idx_t            adj_rd_addr;
    row_t            adj_rd_reg;
    logic            adj_rd_vld_reg;
    logic            adj_wr_en;
    row_t            adj_wr_data;
    logic            stk_rd_en;
    logic [SI_W-1:0] stk_rd_addr;
    idx_t            stk_rd_reg;
    logic            stk_wr_en;
    idx_t            stk_wr_data;

    // Node limit in use and id checks.
    logic [LW-1:0]   cnt_ext;
    logic [LW-1:0]   limit;
    logic [LW-1:0]   from_ext, to_ext;
    logic [LW-1:0]   from_m1, to_m1;
    logic            ids_ok;
    row_t            lim_mask;
    row_t            adj_row;
    row_t            cand;
    logic            out_free;
    logic            in_fire;

    assign cnt_ext  = LW'(node_count_reg);
    assign limit    = (cnt_ext > LW'(MAX_NODES)) ? LW'(MAX_NODES) : cnt_ext;
    assign from_ext = LW'(in_ch.from_node);
    assign to_ext   = LW'(in_ch.to_node);
    assign from_m1  = from_ext - LW'(1);
    assign to_m1    = to_ext - LW'(1);
    assign ids_ok   = (from_ext != '0) && (from_ext <= limit)
                   && (to_ext != '0) && (to_ext <= limit);

    always_comb
    begin
        for (int i = 0; i < MAX_NODES; i++)
        begin
            lim_mask[i] = (LW'(i) < limit);
        end
    end

    // A row that was never written since reset or the last clear reads as empty.
    assign adj_row = adj_rd_vld_reg ? adj_rd_reg : '0;
    // Neighbors still to be discovered, restricted to the nodes in use.
    assign cand    = adj_row & lim_mask & ~disc_reg;

    assign in_ch.ready      = (state_reg == S_IDLE);
    assign in_fire          = in_ch.valid && in_ch.ready;
    assign out_free         = !out_valid_reg || out_ch.ready;
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.reachable = out_reach_reg;
    assign out_ch.bad_node  = out_bad_reg;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        row_vld_next   = row_vld_reg;
        disc_next      = disc_reg;
        pend_next      = pend_reg;
        fill_next      = fill_reg;
        res_reach_next = res_reach_reg;
        res_bad_next   = res_bad_reg;
        from_idx_next  = from_idx_reg;
        to_idx_next    = to_idx_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_reach_next = out_reach_reg;
        out_bad_next   = out_bad_reg;
        adj_rd_en      = 1'b0;
        adj_rd_addr    = from_idx_reg;
        adj_wr_en      = 1'b0;
        adj_wr_data    = adj_row | (row_t'(1) << to_idx_reg);
        stk_rd_en      = 1'b0;
        stk_rd_addr    = fill_reg[SI_W-1:0] - SI_W'(1);
        stk_wr_en      = 1'b0;
        stk_wr_data    = first_set(pend_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    from_idx_next  = from_m1[IDX_W-1:0];
                    to_idx_next    = to_m1[IDX_W-1:0];
                    res_reach_next = 1'b0;
                    res_bad_next   = 1'b0;
                    state_next     = S_DONE;
                    unique case (in_ch.op)
                        OP_ADD_EDGE:
                        begin
                            if (ids_ok)
                            begin
                                state_next = S_ADD_RD;
                            end
                            else
                            begin
                                res_bad_next = 1'b1;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (ids_ok)
                            begin
                                disc_next  = '0;
                                fill_next  = '0;
                                state_next = S_Q_RD;
                            end
                            else
                            begin
                                res_bad_next = 1'b1;
                            end
                        end
                        OP_CLEAR_ALL:
                        begin
                            row_vld_next = '0;
                        end
                        OP_UNUSED:
                        begin
                        end
                    endcase
                end
            end
            S_ADD_RD:
            begin
                adj_rd_en  = 1'b1;
                state_next = S_ADD_WR;
            end
            S_ADD_WR:
            begin
                adj_wr_en                  = 1'b1;
                row_vld_next[from_idx_reg] = 1'b1;
                state_next                 = S_DONE;
            end
            S_Q_RD:
            begin
                // The start row is read without marking the start node.
                adj_rd_en  = 1'b1;
                state_next = S_Q_EXP;
            end
            S_Q_EXP:
            begin
                if (cand[to_idx_reg])
                begin
                    res_reach_next = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    disc_next  = disc_reg | cand;
                    pend_next  = cand;
                    state_next = S_Q_PUSH;
                end
            end
            S_Q_PUSH:
            begin
                if (pend_reg == '0)
                begin
                    state_next = S_Q_POP;
                end
                else
                begin
                    stk_wr_en                    = 1'b1;
                    pend_next[first_set(pend_reg)] = 1'b0;
                    fill_next                    = fill_reg + SF_W'(1);
                end
            end
            S_Q_POP:
            begin
                if (fill_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    stk_rd_en  = 1'b1;
                    fill_next  = fill_reg - SF_W'(1);
                    state_next = S_Q_POPW;
                end
            end
            S_Q_POPW:
            begin
                // The popped node goes straight to the adjacency read port.
                adj_rd_en   = 1'b1;
                adj_rd_addr = stk_rd_reg;
                state_next  = S_Q_EXP;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_reach_next = res_reach_reg;
                    out_bad_next   = res_bad_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= NODE_CNT_RST;
            row_vld_reg    <= '0;
            disc_reg       <= '0;
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_vld_reg   <= row_vld_next;
            disc_reg      <= disc_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                node_count_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_reg      <= pend_next;
        res_reach_reg <= res_reach_next;
        res_bad_reg   <= res_bad_next;
        from_idx_reg  <= from_idx_next;
        to_idx_reg    <= to_idx_next;
        out_reach_reg <= out_reach_next;
        out_bad_reg   <= out_bad_next;
    end

    // Adjacency memory, one read and one write port, registered read data.
    always_ff @(posedge clk)
    begin
        if (adj_wr_en)
        begin
            adj_mem[from_idx_reg] <= adj_wr_data;
        end
        if (adj_rd_en)
        begin
            adj_rd_reg     <= adj_mem[adj_rd_addr];
            adj_rd_vld_reg <= row_vld_reg[adj_rd_addr];
        end
    end

    // Walk stack memory.
    always_ff @(posedge clk)
    begin
        if (stk_wr_en)
        begin
            stk_mem[fill_reg[SI_W-1:0]] <= stk_wr_data;
        end
        if (stk_rd_en)
        begin
            stk_rd_reg <= stk_mem[stk_rd_addr];
        end
    end

endmodule

/* rtl/grdfs_checker.sv */
// Port-level checker for the reachability unit and its bind to the top level.
module grdfs_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic reachable,
    input logic bad_node
);
    logic [1:0] pend_reg, pend_next;
    logic       in_fire, out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg + 2'(in_fire) - 2'(out_fire);
    end

    // Commands accepted but whose result beat has not been taken yet.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped before it was taken");

    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |-> pend_reg != 2'd0)
        else $error("result beat without a pending command");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 2'd2 |-> !in_ready)
        else $error("command accepted while one is in work and one waits");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(reachable && bad_node))
        else $error("reachable set on a rejected command");

endmodule

bind graph_reachability_dfs_unit grdfs_checker u_grdfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .reachable (out_ch.reachable),
    .bad_node  (out_ch.bad_node)
);
